>>> hdl/pidp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidp_pkg
// Shared types and constants of the PID position loop.
// ----------------------------------------------------------------------------
package pidp_pkg;

    localparam int GAIN_W   = 24;
    localparam int POS_W    = 32;
    localparam int DT_W     = 24;
    localparam int LIM_W    = 31;
    localparam int ERR_W    = 33;
    localparam int SUM_W    = 48;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    localparam int NUM_W    = 54;
    localparam int MAG_W    = 72;
    localparam int TERM_W   = 80;
    localparam int ACC_W    = 84;
    localparam int CHUNKS   = 3;

    localparam logic [IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_TARGET      = 3'd3;
    localparam logic [IDX_W-1:0] CFG_LIMIT       = 3'd4;
    localparam logic [IDX_W-1:0] CFG_DEADBAND    = 3'd5;
    localparam logic [IDX_W-1:0] CFG_INVERT      = 3'd6;

    localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 24'd524288;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 24'd26214;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = 24'd19661;
    localparam logic [POS_W-1:0]  RST_TARGET     = 32'd393216;
    localparam logic [LIM_W-1:0]  RST_LIMIT      = 31'd327680;
    localparam logic [LIM_W-1:0]  RST_DEADBAND   = 31'd52429;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic [DT_W-1:0]         dt;
    } t_item;

    typedef struct packed {
        logic [GAIN_W-1:0]       prop_gain;
        logic [GAIN_W-1:0]       integ_gain;
        logic [GAIN_W-1:0]       deriv_gain;
        logic signed [POS_W-1:0] target_position;
        logic [LIM_W-1:0]        output_limit;
        logic [LIM_W-1:0]        deadband;
        logic                    invert_output;
    } t_cfg;

endpackage

>>> hdl/pidp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidp_front
// Input side: takes samples, drops those with zero elapsed time and queues
// the rest in a two-entry queue for the arithmetic engine.
// ----------------------------------------------------------------------------
module pidp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  pidp_pkg::t_item i_item,
    output logic            o_item_valid,
    output pidp_pkg::t_item o_item,
    input  logic            i_pop
);
    import pidp_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_accept;
    logic       w_push;
    logic       w_pop;

    assign o_stall      = (r_count == 2'd2);
    assign w_accept     = i_valid && !o_stall;
    // A sample with zero elapsed time gives no result and leaves the state alone.
    assign w_push       = w_accept && (i_item.dt != '0);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_pop        = i_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

>>> hdl/pidp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidp_back
// Arithmetic engine: integral update, bit-serial derivative division, three
// gain products on one shared 24x24 multiplier, then clamp, inversion and
// deadband into the output register.
// ----------------------------------------------------------------------------
module pidp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pidp_pkg::t_cfg                  i_cfg,
    input  logic                            i_item_valid,
    input  pidp_pkg::t_item                 i_item,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [pidp_pkg::POS_W-1:0] o_drive
);
    import pidp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_IMUL = 3'd1;
    localparam logic [2:0] S_IADD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]                r_state;
    logic [5:0]                r_cnt;
    logic [1:0]                r_sel;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   r_last_error;
    logic signed [SUM_W-1:0]   r_error_sum;
    logic [DT_W-1:0]           r_dt;
    logic [NUM_W-1:0]          r_num;
    logic                      r_dneg;
    logic [DT_W-1:0]           r_rem;
    logic [NUM_W-1:0]          r_quo;
    logic [MAG_W-1:0]          r_mag;
    logic [TERM_W-1:0]         r_term;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    logic signed [POS_W-1:0]   r_drive;

    logic signed [ERR_W-1:0]   w_err;
    logic signed [ERR_W:0]     w_diff;
    logic [ERR_W:0]            w_diff_mag;
    logic [ERR_W-1:0]          w_err_mag;
    logic [ERR_W-1:0]          w_rerr_mag;
    logic [SUM_W-1:0]          w_sum_mag;
    logic [GAIN_W-1:0]         w_mul_a;
    logic [2*GAIN_W-1:0]       w_prod;
    logic [TERM_W-1:0]         w_term_next;
    logic signed [57:0]        w_incr_full;
    logic signed [SUM_W:0]     w_sum_next;
    logic [DT_W:0]             w_rem_sh;
    logic                      w_qbit;
    logic                      w_term_neg;
    logic signed [ACC_W-1:0]   w_term_s;
    logic signed [ACC_W-16-1:0] w_sh;
    logic signed [ACC_W-16-1:0] w_lim;
    logic signed [POS_W-1:0]   w_clamped;
    logic signed [POS_W-1:0]   w_final;
    logic                      w_start;

    assign w_start    = (r_state == S_IDLE) && i_item_valid && !r_out_valid;
    assign o_pop      = w_start;
    assign w_err      = ERR_W'(i_cfg.target_position) - ERR_W'(i_item.pos);
    assign w_diff     = (ERR_W+1)'(w_err) - (ERR_W+1)'(r_last_error);
    assign w_diff_mag = w_diff[ERR_W] ? (ERR_W+1)'(-w_diff) : w_diff;
    assign w_err_mag  = w_err[ERR_W-1] ? ERR_W'(-w_err) : w_err;
    assign w_rerr_mag = r_err[ERR_W-1] ? ERR_W'(-r_err) : r_err;
    assign w_sum_mag  = r_error_sum[SUM_W-1] ? SUM_W'(-r_error_sum) : r_error_sum;

    always_comb begin
        unique case (r_sel)
            2'd0:    w_mul_a = i_cfg.prop_gain;
            2'd1:    w_mul_a = i_cfg.integ_gain;
            default: w_mul_a = i_cfg.deriv_gain;
        endcase
        if (r_state == S_IMUL) begin
            w_mul_a = r_dt;
        end
    end

    // Chunks go in from the most significant end, so the partial sum only
    // ever shifts by a fixed 24 bits.
    assign w_prod      = w_mul_a * r_mag[MAG_W-1 -: GAIN_W];
    assign w_term_next = {r_term[TERM_W-GAIN_W-1:0], {GAIN_W{1'b0}}}
                         + TERM_W'(w_prod);

    // error * dt is below 2^57 in magnitude; floor by 2^20 via arithmetic shift.
    assign w_incr_full = r_err[ERR_W-1] ? -$signed({1'b0, r_term[56:0]})
                                        : $signed({1'b0, r_term[56:0]});
    assign w_sum_next  = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(w_incr_full >>> 20);

    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_dt});

    always_comb begin
        unique case (r_sel)
            2'd0:    w_term_neg = r_err[ERR_W-1];
            2'd1:    w_term_neg = r_error_sum[SUM_W-1];
            default: w_term_neg = r_dneg;
        endcase
    end
    assign w_term_s = w_term_neg ? -$signed(ACC_W'(r_term)) : $signed(ACC_W'(r_term));

    assign w_sh  = r_acc[ACC_W-1:16];
    assign w_lim = $signed((ACC_W-16)'(i_cfg.output_limit));

    always_comb begin
        priority if (w_sh > w_lim) begin
            w_clamped = POS_W'(w_lim);
        end else if (w_sh < -w_lim) begin
            w_clamped = POS_W'(-w_lim);
        end else begin
            w_clamped = w_sh[POS_W-1:0];
        end
        w_final = i_cfg.invert_output ? -w_clamped : w_clamped;
        if (w_rerr_mag <= ERR_W'(i_cfg.deadband)) begin
            w_final = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_error_sum  <= '0;
            r_last_error <= '0;
            r_cnt        <= '0;
            r_sel        <= '0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_err        <= w_err;
                        r_last_error <= w_err;
                        r_num        <= {w_diff_mag, 20'b0};
                        r_dneg       <= w_diff[ERR_W];
                        r_dt         <= i_item.dt;
                        r_mag        <= MAG_W'(w_err_mag);
                        r_term       <= '0;
                        r_acc        <= '0;
                        r_cnt        <= '0;
                        r_sel        <= '0;
                        r_state      <= S_IMUL;
                    end
                end
                S_IMUL, S_MUL: begin
                    r_term <= w_term_next;
                    r_mag  <= {r_mag[MAG_W-GAIN_W-1:0], {GAIN_W{1'b0}}};
                    if (r_cnt == 6'(CHUNKS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= (r_state == S_IMUL) ? S_IADD : S_ACC;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_IADD: begin
                    if (w_sum_next > $signed({2'b00, {(SUM_W-1){1'b1}}})) begin
                        r_error_sum <= {1'b0, {(SUM_W-1){1'b1}}};
                    end else if (w_sum_next < $signed({2'b11, {(SUM_W-1){1'b0}}})) begin
                        r_error_sum <= {1'b1, {(SUM_W-1){1'b0}}};
                    end else begin
                        r_error_sum <= w_sum_next[SUM_W-1:0];
                    end
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_qbit ? DT_W'(w_rem_sh - {1'b0, r_dt}) : w_rem_sh[DT_W-1:0];
                    r_quo <= {r_quo[NUM_W-2:0], w_qbit};
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    if (r_cnt == 6'(NUM_W - 1)) begin
                        r_cnt   <= '0;
                        r_sel   <= '0;
                        r_mag   <= MAG_W'(w_rerr_mag);
                        r_term  <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_ACC: begin
                    r_acc  <= r_acc + w_term_s;
                    r_term <= '0;
                    if (r_sel == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_mag   <= (r_sel == 2'd0) ? MAG_W'(w_sum_mag) : MAG_W'(r_quo);
                        r_sel   <= r_sel + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    r_drive     <= w_final;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

`ifndef SYNTH
    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == S_IMUL))
        else $error("engine did not start after taking an item");

    a_no_start_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_pop)
        else $error("item taken while a result is still held");

    a_result_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not registered at the end of an item");
`endif

endmodule

>>> hdl/pid_position_loop_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_loop_core
// Fixed-point PID position controller with clamp, inversion and deadband.
// ----------------------------------------------------------------------------
// Usage: samples (measured position, elapsed time) enter on the input
// channel; a transaction completes when i_in_valid is high and o_in_stall is
// low. A sample with zero elapsed time is dropped and gives no drive value.
// Every other sample gives one drive value on the output channel, taken when
// o_out_valid is high and i_out_stall is low.
// A sample taken by an idle block passes the queue register, then the engine;
// the 54-step bit-serial division of the derivative is most of its work, the
// rest the shared 24x24 multiplier (twelve chunks) and five steps of
// bookkeeping. The engine takes one sample at a time, the next only once the
// last drive value is taken. A two-entry queue sits ahead of the engine, so
// samples are taken while a result waits; when the receiver stalls, the
// result is held and the engine waits, and once the queue is full o_in_stall
// rises. Registers are written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must write them only while the block is idle, which the block
// does not enforce. Unknown indexes are ignored. Reset (synchronous, active
// low) restores default gains and clears the integral and the last error.
// ----------------------------------------------------------------------------
module pid_position_loop_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [pidp_pkg::POS_W-1:0]    i_measured_position,
    input  logic [pidp_pkg::DT_W-1:0]            i_elapsed_time,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [pidp_pkg::POS_W-1:0]    o_drive,
    input  logic                                 i_cfg_we,
    input  logic [pidp_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [pidp_pkg::CFG_W-1:0]           i_cfg_data
);
    import pidp_pkg::*;

    t_cfg  r_cfg;
    t_item w_in_item;
    t_item w_q_item;
    logic  w_q_valid;
    logic  w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain       <= RST_PROP_GAIN;
            r_cfg.integ_gain      <= RST_INTEG_GAIN;
            r_cfg.deriv_gain      <= RST_DERIV_GAIN;
            r_cfg.target_position <= RST_TARGET;
            r_cfg.output_limit    <= RST_LIMIT;
            r_cfg.deadband        <= RST_DEADBAND;
            r_cfg.invert_output   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:  r_cfg.prop_gain       <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: r_cfg.integ_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN: r_cfg.deriv_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_TARGET:     r_cfg.target_position <= i_cfg_data[POS_W-1:0];
                CFG_LIMIT:      r_cfg.output_limit    <= i_cfg_data[LIM_W-1:0];
                CFG_DEADBAND:   r_cfg.deadband        <= i_cfg_data[LIM_W-1:0];
                CFG_INVERT:     r_cfg.invert_output   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_in_item.pos = i_measured_position;
    assign w_in_item.dt  = i_elapsed_time;

    pidp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_item       (w_in_item),
        .o_item_valid (w_q_valid),
        .o_item       (w_q_item),
        .i_pop        (w_pop)
    );

    pidp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_q_valid),
        .i_item       (w_q_item),
        .o_pop        (w_pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_drive      (o_drive)
    );

endmodule
